@@ hdl/alle_pkg.sv @@
// Package for the array linked list engine: action and status codes,
// datapath operations, jump conditions and the microprogram ROM.
// No dependencies.
package alle_pkg;

  localparam logic [1:0] ACT_HEAD = 2'd0;
  localparam logic [1:0] ACT_TAIL = 2'd1;
  localparam logic [1:0] ACT_POS  = 2'd2;
  localparam logic [1:0] ACT_READ = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_POS  = 2'd2;

  typedef logic [3:0] step_t;

  localparam step_t S_IDLE     = 4'd0;
  localparam step_t S_PRIME    = 4'd1;
  localparam step_t S_CHKFULL  = 4'd2;
  localparam step_t S_CHKHEAD  = 4'd3;
  localparam step_t S_WALK     = 4'd4;
  localparam step_t S_CHKREAD  = 4'd5;
  localparam step_t S_WRNEW    = 4'd6;
  localparam step_t S_LINKPREV = 4'd7;
  localparam step_t S_PUTHEAD  = 4'd8;
  localparam step_t S_EMITRD   = 4'd9;
  localparam step_t S_ERRPOS   = 4'd10;
  localparam step_t S_ERRFULL  = 4'd11;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LATCH,
    OP_PRIME,
    OP_WALK,
    OP_WRITE_NEW,
    OP_LINK_PREV,
    OP_PUT_HEAD,
    OP_EMIT_RD,
    OP_ERR_POS,
    OP_ERR_FULL
  } dp_op_e;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NOSTART,
    C_BADPOS,
    C_FULL,
    C_ATHEAD,
    C_KNZ,
    C_READ
  } cond_e;

  typedef struct packed {
    dp_op_e op;
    cond_e  cond;
    step_t  target;
  } ctl_t;

  typedef struct packed {
    logic bad_pos;
    logic full_ins;
    logic at_head;
    logic k_nz;
    logic is_read;
  } flags_t;

  // Jump to target when the condition holds, else fall through to the next step.
  function automatic ctl_t ucode(step_t s);
    ctl_t w;
    case (s)
      S_IDLE:     w = '{OP_LATCH,     C_NOSTART, S_IDLE};
      S_PRIME:    w = '{OP_PRIME,     C_BADPOS,  S_ERRPOS};
      S_CHKFULL:  w = '{OP_NOP,       C_FULL,    S_ERRFULL};
      S_CHKHEAD:  w = '{OP_NOP,       C_ATHEAD,  S_PUTHEAD};
      S_WALK:     w = '{OP_WALK,      C_KNZ,     S_WALK};
      S_CHKREAD:  w = '{OP_NOP,       C_READ,    S_EMITRD};
      S_WRNEW:    w = '{OP_WRITE_NEW, C_ALWAYS,  S_LINKPREV};
      S_LINKPREV: w = '{OP_LINK_PREV, C_ALWAYS,  S_IDLE};
      S_PUTHEAD:  w = '{OP_PUT_HEAD,  C_ALWAYS,  S_IDLE};
      S_EMITRD:   w = '{OP_EMIT_RD,   C_ALWAYS,  S_IDLE};
      S_ERRPOS:   w = '{OP_ERR_POS,   C_ALWAYS,  S_IDLE};
      S_ERRFULL:  w = '{OP_ERR_FULL,  C_ALWAYS,  S_IDLE};
      default:    w = '{OP_NOP,       C_ALWAYS,  S_IDLE};
    endcase
    return w;
  endfunction

endpackage

@@ hdl/alle_seq.sv @@
// Microprogram sequencer: step counter, control ROM and conditional jumps.
// Depends on alle_pkg.
module alle_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  alle_pkg::flags_t flags_i,
  output alle_pkg::ctl_t  ctl_o,
  output logic            busy_o
);
  import alle_pkg::*;

  step_t step_q, step_d;
  ctl_t  ctl;
  logic  hit;

  assign ctl = ucode(step_q);

  always_comb begin
    case (ctl.cond)
      C_ALWAYS:  hit = 1'b1;
      C_NOSTART: hit = !start_i;
      C_BADPOS:  hit = flags_i.bad_pos;
      C_FULL:    hit = flags_i.full_ins;
      C_ATHEAD:  hit = flags_i.at_head;
      C_KNZ:     hit = flags_i.k_nz;
      C_READ:    hit = flags_i.is_read;
      default:   hit = 1'b0;
    endcase
    step_d = hit ? ctl.target : step_q + step_t'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctl_o  = ctl;
  assign busy_o = (step_q != S_IDLE);

endmodule

@@ hdl/alle_dp.sv @@
// Datapath: data and link memories, head, count, walk pointer and counter,
// result registers. Driven one operation a cycle by alle_seq; uses alle_pkg.
module alle_dp #(
  parameter int CAPACITY = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  alle_pkg::ctl_t      ctl_i,
  input  logic [1:0]          action_i,
  input  logic signed [31:0]  value_i,
  input  logic [7:0]          position_i,
  output alle_pkg::flags_t    flags_o,
  output logic                done_o,
  output logic signed [31:0]  read_value_o,
  output logic [1:0]          status_o,
  output logic [8:0]          item_count_o,
  output logic                is_full_o,
  output logic                is_empty_o
);
  import alle_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int LW = IW + 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = CW + 8;
  localparam logic [LW-1:0] NIL = LW'(CAPACITY);

  logic [31:0]    data_mem [CAPACITY];
  logic [LW-1:0]  link_mem [CAPACITY];

  logic [1:0]     act_q;
  logic [31:0]    val_q;
  logic [7:0]     pos_q;
  logic [LW-1:0]  head_q;
  logic [CW-1:0]  cnt_q;
  logic [LW-1:0]  cur_q;
  logic [CW-1:0]  k_q, k_init;
  logic [LW-1:0]  lnk_rd_q;
  logic [31:0]    data_rd_q;
  logic           done_q;
  logic [31:0]    rdval_q;
  logic [1:0]     status_q;

  logic [IW-1:0]  rd_addr, wr_addr, new_slot;
  logic           link_we, data_we;
  logic [LW-1:0]  link_wd;
  logic           advance;
  logic [EW-1:0]  pos_w, cnt_w;

  // Slots leave the free chain in index order and never return, so the free
  // head always equals the count: the next free slot is the count itself.
  assign new_slot = cnt_q[IW-1:0];
  assign advance  = (ctl_i.op == OP_WALK) && (k_q != '0);

  assign pos_w = EW'(pos_q);
  assign cnt_w = EW'(cnt_q);

  assign flags_o.is_read  = (act_q == ACT_READ);
  assign flags_o.bad_pos  = ((act_q == ACT_READ) && (pos_w >= cnt_w)) ||
                            ((act_q == ACT_POS) && (pos_w > cnt_w));
  assign flags_o.full_ins = (act_q != ACT_READ) && (cnt_q == CW'(CAPACITY));
  assign flags_o.at_head  = (act_q != ACT_READ) &&
                            ((act_q == ACT_HEAD) || (cnt_q == '0) ||
                             ((act_q == ACT_POS) && (pos_q == '0)));
  assign flags_o.k_nz     = (k_q != '0);

  // Links to follow from the head: predecessor for inserts, target for reads.
  always_comb begin
    case (act_q)
      ACT_READ: k_init = CW'(pos_q);
      ACT_TAIL: k_init = cnt_q - CW'(1);
      default:  k_init = CW'(pos_q) - CW'(1);
    endcase
  end

  // Read port follows the walk so that lnk_rd_q and data_rd_q track cur_q.
  always_comb begin
    if (ctl_i.op == OP_PRIME) begin
      rd_addr = head_q[IW-1:0];
    end else if (advance) begin
      rd_addr = lnk_rd_q[IW-1:0];
    end else begin
      rd_addr = cur_q[IW-1:0];
    end
  end

  always_comb begin
    link_we = 1'b0;
    data_we = 1'b0;
    wr_addr = new_slot;
    link_wd = lnk_rd_q;
    case (ctl_i.op)
      OP_WRITE_NEW: begin
        link_we = 1'b1;
        data_we = 1'b1;
      end
      OP_LINK_PREV: begin
        link_we = 1'b1;
        wr_addr = cur_q[IW-1:0];
        link_wd = LW'(new_slot);
      end
      OP_PUT_HEAD: begin
        link_we = 1'b1;
        data_we = 1'b1;
        link_wd = head_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[wr_addr] <= link_wd;
    end
    if (data_we) begin
      data_mem[wr_addr] <= val_q;
    end
    lnk_rd_q  <= link_mem[rd_addr];
    data_rd_q <= data_mem[rd_addr];
  end

  // Item payload and walk registers.
  always_ff @(posedge clk_i) begin
    case (ctl_i.op)
      OP_LATCH: begin
        act_q <= action_i;
        val_q <= value_i;
        pos_q <= position_i;
      end
      OP_PRIME: begin
        cur_q <= head_q;
        k_q   <= k_init;
      end
      OP_WALK: begin
        if (advance) begin
          cur_q <= lnk_rd_q;
          k_q   <= k_q - CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= NIL;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      case (ctl_i.op)
        OP_LINK_PREV: begin
          cnt_q  <= cnt_q + CW'(1);
          done_q <= 1'b1;
        end
        OP_PUT_HEAD: begin
          head_q <= LW'(new_slot);
          cnt_q  <= cnt_q + CW'(1);
          done_q <= 1'b1;
        end
        OP_EMIT_RD, OP_ERR_POS, OP_ERR_FULL: begin
          done_q <= 1'b1;
        end
        default: begin
          done_q <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctl_i.op)
      OP_EMIT_RD: begin
        rdval_q  <= data_rd_q;
        status_q <= ST_OK;
      end
      OP_ERR_POS: begin
        rdval_q  <= '0;
        status_q <= ST_POS;
      end
      OP_ERR_FULL: begin
        rdval_q  <= '0;
        status_q <= ST_FULL;
      end
      OP_LINK_PREV, OP_PUT_HEAD: begin
        rdval_q  <= '0;
        status_q <= ST_OK;
      end
      default: begin
      end
    endcase
  end

  assign done_o       = done_q;
  assign read_value_o = signed'(rdval_q);
  assign status_o     = status_q;
  assign item_count_o = 9'(cnt_q);
  assign is_full_o    = (cnt_q == CW'(CAPACITY));
  assign is_empty_o   = (cnt_q == '0);

endmodule

@@ hdl/array_linked_list_engine.sv @@
// Array linked list engine, top level: joins the microprogram sequencer
// and the datapath. Depends on alle_pkg, alle_seq and alle_dp.
//
// Use: raise start_i with action_i, value_i and position_i; the item is
// taken at the rising edge where start_i is high and busy_o is low. busy_o
// then stays high until the item is finished. The result appears on
// read_value_o, status_o, item_count_o, is_full_o and is_empty_o, marked
// by done_o for exactly one cycle, in the first cycle with busy_o low
// again; the block may take the next item in that same cycle. There is no
// back-pressure on results: the receiver must take done_o when it comes.
// Timing: the microprogram walks one link per cycle through the link
// memory's registered read port. Each item first primes the walk at the
// head. A position error ends there; otherwise the item checks for a full
// list (a full error ends there) and then for a head insert, which writes
// the new slot as head. Else the walk follows k links, where k is position
// for a read and position - 1 or count - 1 for inserts; then a read emits
// the data; an insert writes the new slot and links its predecessor to it.
// Reset: the list is empty and all slots are free; no clearing pass runs,
// so the block takes an item in the first cycle after reset.
module array_linked_list_engine #(
  parameter int CAPACITY = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         action_i,
  input  logic signed [31:0] value_i,
  input  logic [7:0]         position_i,
  output logic               done_o,
  output logic signed [31:0] read_value_o,
  output logic [1:0]         status_o,
  output logic [8:0]         item_count_o,
  output logic               is_full_o,
  output logic               is_empty_o
);
  import alle_pkg::*;

  ctl_t   ctl;
  flags_t flags;

  alle_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .flags_i (flags),
    .ctl_o   (ctl),
    .busy_o  (busy_o)
  );

  alle_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .action_i     (action_i),
    .value_i      (value_i),
    .position_i   (position_i),
    .flags_o      (flags),
    .done_o       (done_o),
    .read_value_o (read_value_o),
    .status_o     (status_o),
    .item_count_o (item_count_o),
    .is_full_o    (is_full_o),
    .is_empty_o   (is_empty_o)
  );

endmodule

@@ hdl/alle_chk.sv @@
// Port-level checker for the array linked list engine, bound to the top
// level. Depends on alle_pkg.
module alle_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               done_o,
  input logic signed [31:0] read_value_o,
  input logic [1:0]         status_o,
  input logic [8:0]         item_count_o,
  input logic               is_full_o,
  input logic               is_empty_o
);
  import alle_pkg::*;

  // An accepted item occupies the block.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted item did not raise busy");

  // Results come only once the item is finished.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result shown while busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // A full error leaves the list full.
  a_full_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == ST_FULL) |-> is_full_o && !is_empty_o)
    else $error("full status without a full list");

  // A failed item leaves the count as it was and returns zero data.
  a_err_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != ST_OK) |-> (read_value_o == '0) &&
      (item_count_o == $past(item_count_o)))
    else $error("failed item changed the count or returned data");

endmodule

bind array_linked_list_engine alle_chk u_alle_chk (.*);
